// ===== src/srg_pkg.sv =====
// shared types, constants and an arithmetic helper for the subtractive generator
// depends on nothing; imported by srg_mem, srg_ctrl and subtractive_random_generator
package srg_pkg;

	localparam int TABLE_LEN    = 55;
	localparam int WORD_W       = 30;
	localparam int IDX_W        = 6;
	localparam int ADDR_W       = $clog2(TABLE_LEN);
	localparam int SEED_W       = 16;
	localparam int LAG_OFFSET   = 30;
	localparam int SECOND_START = 31;
	localparam int FILL_COUNT   = 54;
	localparam int SPREAD       = 21;
	localparam int WARM_PASSES  = 4;

	localparam logic [WORD_W-1:0] MODULUS   = 30'd1000000000;
	localparam logic [WORD_W-1:0] MAX_WORD  = 30'd999999999;
	localparam logic [WORD_W-1:0] SEED_BASE = 30'd161803398;

	// status word numbers for restore and dump
	localparam logic [IDX_W-1:0] WIDX_FIRST  = 6'd55;
	localparam logic [IDX_W-1:0] WIDX_SECOND = 6'd56;

	typedef enum logic [1:0] {
		CMD_SEED    = 2'd0,
		CMD_DRAW    = 2'd1,
		CMD_DUMP    = 2'd2,
		CMD_RESTORE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] raddr_a;
		logic [ADDR_W-1:0] raddr_b;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic              load;
		logic [WORD_W-1:0] value;
		logic              last;
	} out_load_t;

	// (a - b) mod 10^9 for a, b below 10^9
	function automatic logic [WORD_W-1:0] sub_mod(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[WORD_W]) begin
			d = d + {1'b0, MODULUS};
		end
		return d[WORD_W-1:0];
	endfunction

endpackage

// ===== src/subtractive_random_generator.sv =====
// top level of the lagged subtractive random generator (modulo 10^9, 55-word table)
// depends on srg_pkg, srg_mem and srg_ctrl
//
// usage:
//  - input channel s_*: one item per command; s_tuser carries the command (0 seed,
//    1 draw, 2 dump state, 3 restore one state word), s_tdata the seed and restore fields
//  - output channel m_*: result items; m_tdata carries a random integer (draw), a state
//    word (dump) or zero (acknowledge of seed and restore); m_tlast marks the final
//    result item of a command
//  - a draw reads both lag entries through the registered read ports, then subtracts and
//    writes back once the output register is free
//  - a restore writes, then acknowledges
//  - a seed does 1 + 54 scattered fill writes, then 4 warm-up passes of 55 read/write
//    pairs, then the acknowledge
//  - a dump gives 57 result items, each read, then output
//  - one command is in work at a time; a new item is taken once the previous command's
//    last result sits in the output register, even while that result still waits
//  - when the receiver stalls, the output register holds its item and the sequencer waits
//  - after reset the table reads as all zeros and both indices are zero, so draws
//    before seeding give zeros
module subtractive_random_generator import srg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // seed[15:0], word_index[21:16], word_value[51:22], zero pad
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // value[29:0], zero pad
	output logic        m_tlast
);

	mem_req_t          mem_req;
	out_load_t         out_load;
	logic [WORD_W-1:0] rd_a;
	logic [WORD_W-1:0] rd_b;
	logic              out_free;
	cmd_t              in_cmd;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_value_q;
	logic              out_last_q;

	assign in_cmd   = cmd_t'(s_tuser);
	// output slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || m_tready;

	srg_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rd_a   (rd_a),
		.rd_b   (rd_b)
	);

	srg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (in_cmd),
		.in_seed  (s_tdata[15:0]),
		.in_widx  (s_tdata[21:16]),
		.in_wval  (s_tdata[51:22]),
		.out_free (out_free),
		.rd_a     (rd_a),
		.rd_b     (rd_b),
		.mem_req  (mem_req),
		.out_load (out_load)
	);

	// output register between the sequencer and the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load.load) begin
				out_valid_q <= 1'b1;
				out_value_q <= out_load.value;
				out_last_q  <= out_load.last;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_value_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== src/srg_mem.sv =====
// lag table storage: one write port, two registered read ports, per-entry valid bits
// depends on srg_pkg
module srg_mem import srg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_req_t          req,
	output logic [WORD_W-1:0] rd_a,
	output logic [WORD_W-1:0] rd_b
);

	logic [WORD_W-1:0]    mem [TABLE_LEN];
	logic [TABLE_LEN-1:0] valid_q;
	logic [WORD_W-1:0]    rdata_a_q;
	logic [WORD_W-1:0]    rdata_b_q;
	logic                 rvalid_a_q;
	logic                 rvalid_b_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_a_q <= mem[req.raddr_a];
			rdata_b_q <= mem[req.raddr_b];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rvalid_a_q <= 1'b0;
			rvalid_b_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_a_q <= valid_q[req.raddr_a];
				rvalid_b_q <= valid_q[req.raddr_b];
			end
		end
	end

	assign rd_a = rvalid_a_q ? rdata_a_q : '0;
	assign rd_b = rvalid_b_q ? rdata_b_q : '0;

endmodule

// ===== src/srg_ctrl.sv =====
// command sequencer: seeding, warm-up, draws, dumps and restores on the lag table
// depends on srg_pkg; drives srg_mem and the output register in the top level
module srg_ctrl import srg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cmd_t              in_cmd,
	input  logic [SEED_W-1:0] in_seed,
	input  logic [IDX_W-1:0]  in_widx,
	input  logic [WORD_W-1:0] in_wval,
	input  logic              out_free,
	input  logic [WORD_W-1:0] rd_a,
	input  logic [WORD_W-1:0] rd_b,
	output mem_req_t          mem_req,
	output out_load_t         out_load
);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_FILL     = 8'b0000_0010,
		ST_WARM_RD  = 8'b0000_0100,
		ST_WARM_WR  = 8'b0000_1000,
		ST_DRAW_WR  = 8'b0001_0000,
		ST_DUMP_RD  = 8'b0010_0000,
		ST_DUMP_OUT = 8'b0100_0000,
		ST_ACK      = 8'b1000_0000
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(TABLE_LEN - 1);
	localparam logic [ADDR_W-1:0] WRAP_ADDR  = ADDR_W'(TABLE_LEN - LAG_OFFSET - 1);
	localparam logic [IDX_W-1:0]  LEN_IDX    = IDX_W'(TABLE_LEN);
	localparam logic [IDX_W-1:0]  ONE_IDX    = IDX_W'(1);
	localparam logic [IDX_W-1:0]  SPREAD_IDX = IDX_W'(SPREAD);
	localparam logic [1:0]        LAST_PASS  = 2'(WARM_PASSES - 1);

	state_t            state_q;
	logic [IDX_W-1:0]  first_q;
	logic [IDX_W-1:0]  second_q;
	logic [WORD_W-1:0] cur_q;
	logic [WORD_W-1:0] prev_q;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [1:0]        pass_q;

	logic [IDX_W-1:0]  first_nx;
	logic [IDX_W-1:0]  second_nx;
	logic [SEED_W:0]   seed_mag;
	logic [WORD_W-1:0] seed_cur;
	logic [WORD_W-1:0] restore_word;
	logic [IDX_W-1:0]  restore_idx;
	logic [ADDR_W-1:0] warm_b;
	logic [IDX_W:0]    pos_sum;
	logic [WORD_W-1:0] pair_diff;
	logic [WORD_W-1:0] dump_word;

	assign in_ready = (state_q == ST_IDLE);

	// indices step through 1..55
	assign first_nx  = (first_q >= LEN_IDX) ? ONE_IDX : first_q + ONE_IDX;
	assign second_nx = (second_q >= LEN_IDX) ? ONE_IDX : second_q + ONE_IDX;

	// absolute value of the seed, -32768 gives 32768
	assign seed_mag = in_seed[SEED_W-1] ? ~{in_seed[SEED_W-1], in_seed} + 1'b1
	                                    : {1'b0, in_seed};
	assign seed_cur = SEED_BASE - WORD_W'(seed_mag);

	assign restore_word = (in_wval > MAX_WORD) ? MAX_WORD : in_wval;
	assign restore_idx  = (in_wval > WORD_W'(TABLE_LEN)) ? LEN_IDX : in_wval[IDX_W-1:0];

	// warm-up partner of entry cnt_q: position 1 + (i + 30) mod 55
	always_comb begin
		if (cnt_q < WRAP_ADDR) begin
			warm_b = cnt_q + ADDR_W'(LAG_OFFSET + 1);
		end else if (cnt_q == WRAP_ADDR) begin
			warm_b = '0;
		end else begin
			warm_b = cnt_q - WRAP_ADDR;
		end
	end

	assign pos_sum   = {1'b0, pos_q} + {1'b0, SPREAD_IDX};
	assign pair_diff = sub_mod(rd_a, rd_b);

	always_comb begin
		if (cnt_q < LEN_IDX) begin
			dump_word = rd_a;
		end else if (cnt_q == WIDX_FIRST) begin
			dump_word = WORD_W'(first_q);
		end else begin
			dump_word = WORD_W'(second_q);
		end
	end

	always_comb begin
		mem_req  = '0;
		out_load = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_cmd)
						CMD_SEED: begin
							mem_req.we    = 1'b1;
							mem_req.waddr = LAST_ADDR;
							mem_req.wdata = seed_cur;
						end
						CMD_DRAW: begin
							mem_req.rd_en   = 1'b1;
							mem_req.raddr_a = first_nx - ONE_IDX;
							mem_req.raddr_b = second_nx - ONE_IDX;
						end
						CMD_RESTORE: begin
							if (in_widx < LEN_IDX) begin
								mem_req.we    = 1'b1;
								mem_req.waddr = in_widx;
								mem_req.wdata = restore_word;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_FILL: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_q - ONE_IDX;
				mem_req.wdata = prev_q;
			end
			ST_WARM_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.raddr_a = cnt_q;
				mem_req.raddr_b = warm_b;
			end
			ST_WARM_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = cnt_q;
				mem_req.wdata = pair_diff;
			end
			ST_DRAW_WR: begin
				if (out_free) begin
					mem_req.we     = 1'b1;
					mem_req.waddr  = first_q - ONE_IDX;
					mem_req.wdata  = pair_diff;
					out_load.load  = 1'b1;
					out_load.value = pair_diff;
					out_load.last  = 1'b1;
				end
			end
			ST_DUMP_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.raddr_a = (cnt_q < LEN_IDX) ? cnt_q : '0;
				mem_req.raddr_b = '0;
			end
			ST_DUMP_OUT: begin
				if (out_free) begin
					out_load.load  = 1'b1;
					out_load.value = dump_word;
					out_load.last  = (cnt_q == WIDX_SECOND);
				end
			end
			ST_ACK: begin
				if (out_free) begin
					out_load.load = 1'b1;
					out_load.last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			first_q  <= '0;
			second_q <= '0;
			cur_q    <= '0;
			prev_q   <= '0;
			pos_q    <= '0;
			cnt_q    <= '0;
			pass_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (in_cmd)
							CMD_SEED: begin
								cur_q   <= seed_cur;
								prev_q  <= WORD_W'(1);
								pos_q   <= SPREAD_IDX;
								cnt_q   <= ONE_IDX;
								state_q <= ST_FILL;
							end
							CMD_DRAW: begin
								first_q  <= first_nx;
								second_q <= second_nx;
								state_q  <= ST_DRAW_WR;
							end
							CMD_DUMP: begin
								cnt_q   <= '0;
								state_q <= ST_DUMP_RD;
							end
							CMD_RESTORE: begin
								if (in_widx == WIDX_FIRST) begin
									first_q <= restore_idx;
								end
								if (in_widx == WIDX_SECOND) begin
									second_q <= restore_idx;
								end
								state_q <= ST_ACK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FILL: begin
					cur_q  <= prev_q;
					prev_q <= sub_mod(cur_q, prev_q);
					pos_q  <= (pos_sum >= (IDX_W + 1)'(TABLE_LEN))
						? IDX_W'(pos_sum - (IDX_W + 1)'(TABLE_LEN)) : pos_sum[IDX_W-1:0];
					if (cnt_q == IDX_W'(FILL_COUNT)) begin
						cnt_q   <= '0;
						pass_q  <= '0;
						state_q <= ST_WARM_RD;
					end else begin
						cnt_q <= cnt_q + ONE_IDX;
					end
				end
				ST_WARM_RD: begin
					state_q <= ST_WARM_WR;
				end
				ST_WARM_WR: begin
					if (cnt_q == LAST_ADDR) begin
						cnt_q  <= '0;
						pass_q <= pass_q + 2'd1;
						if (pass_q == LAST_PASS) begin
							first_q  <= '0;
							second_q <= IDX_W'(SECOND_START);
							state_q  <= ST_ACK;
						end else begin
							state_q <= ST_WARM_RD;
						end
					end else begin
						cnt_q   <= cnt_q + ONE_IDX;
						state_q <= ST_WARM_RD;
					end
				end
				ST_DRAW_WR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DUMP_RD: begin
					state_q <= ST_DUMP_OUT;
				end
				ST_DUMP_OUT: begin
					if (out_free) begin
						if (cnt_q == WIDX_SECOND) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q   <= cnt_q + ONE_IDX;
							state_q <= ST_DUMP_RD;
						end
					end
				end
				ST_ACK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for subtractive_random_generator: directed table, then random items
// depends on srg_pkg and the generator rtl; predicts every result item of non-fixed rows with its own state copy
`timescale 1ns / 1ps

module testbench;
	import srg_pkg::*;

	localparam int RANDOM_ITEMS = 195;
	localparam int CALM_ITEMS   = 40;   // final stretch with no idling on either side
	localparam int DRAIN_AT     = 100;  // random item before which the sender waits for all results
	localparam int DIRECTED_N   = 25;

	// one result item as it leaves the generator
	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              last;
	} gen_out_t;

	// one row of the directed table; fixed rows carry their own single expected value
	typedef struct packed {
		cmd_t              cmd;
		logic [SEED_W-1:0] seed;
		logic [IDX_W-1:0]  word_index;
		logic [WORD_W-1:0] word_value;
		logic              fixed;
		logic [WORD_W-1:0] fixed_value;
	} dir_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;   // seed[15:0], word_index[21:16], word_value[51:22], zero pad
	logic [1:0]  s_tuser  = '0;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // value[29:0], zero pad
	logic        m_tlast;

	// predictor state: lag table and the two cyclic positions
	logic [WORD_W-1:0] lag_words [TABLE_LEN];
	logic [IDX_W-1:0]  first_pos;
	logic [IDX_W-1:0]  second_pos;

	gen_out_t due_outputs[$];   // results still owed by the generator, oldest first
	gen_out_t step_out[$];      // results of the item just predicted

	int mismatches = 0;
	int stall_left = 0;
	bit idle_on    = 1'b1;

	// directed table: extremes of every field, all commands, the special cases
	dir_row_t directed_rows [DIRECTED_N] = '{
		// draw before seeding works on the all-zero table
		'{CMD_DRAW,    16'h0000, 6'd0,  30'd0,          1'b1, 30'd0},
		'{CMD_DUMP,    16'h0000, 6'd0,  30'd0,          1'b0, 30'd0},
		// oversized table word saturates, acknowledge is zero
		'{CMD_RESTORE, 16'hFFFF, 6'd0,  30'h3FFFFFFF,   1'b1, 30'd0},
		'{CMD_RESTORE, 16'h0000, 6'd54, 30'd999999999,  1'b1, 30'd0},
		// oversized position clips to 55
		'{CMD_RESTORE, 16'h0000, 6'd55, 30'h3FFFFFFF,   1'b1, 30'd0},
		'{CMD_RESTORE, 16'h0000, 6'd56, 30'd0,          1'b1, 30'd0},
		// word numbers above 56 are ignored but still acknowledged
		'{CMD_RESTORE, 16'h0000, 6'd63, 30'h2AAAAAAA,   1'b1, 30'd0},
		'{CMD_RESTORE, 16'h0000, 6'd57, 30'h15555555,   1'b1, 30'd0},
		'{CMD_DUMP,    16'h0000, 6'd0,  30'd0,          1'b0, 30'd0},
		// first position wraps from 55 to 1
		'{CMD_DRAW,    16'h0000, 6'd0,  30'd0,          1'b0, 30'd0},
		'{CMD_DRAW,    16'hFFFF, 6'd63, 30'h3FFFFFFF,   1'b0, 30'd0},
		'{CMD_SEED,    16'h0000, 6'd0,  30'd0,          1'b1, 30'd0},
		'{CMD_DUMP,    16'h0000, 6'd0,  30'd0,          1'b0, 30'd0},
		'{CMD_DRAW,    16'h0000, 6'd0,  30'd0,          1'b0, 30'd0},
		'{CMD_DRAW,    16'h0000, 6'd0,  30'd0,          1'b0, 30'd0},
		'{CMD_SEED,    16'h7FFF, 6'd0,  30'd0,          1'b1, 30'd0},
		'{CMD_DRAW,    16'h0000, 6'd0,  30'd0,          1'b0, 30'd0},
		'{CMD_SEED,    16'h8001, 6'd0,  30'd0,          1'b1, 30'd0},
		// most negative seed gives magnitude 32768
		'{CMD_SEED,    16'h8000, 6'd0,  30'd0,          1'b1, 30'd0},
		'{CMD_DUMP,    16'h0000, 6'd0,  30'd0,          1'b0, 30'd0},
		// first position zero: the draw advances before reading
		'{CMD_RESTORE, 16'h0000, 6'd55, 30'd0,          1'b1, 30'd0},
		'{CMD_DRAW,    16'h0000, 6'd0,  30'd0,          1'b0, 30'd0},
		'{CMD_RESTORE, 16'h0000, 6'd56, 30'd54,         1'b1, 30'd0},
		'{CMD_DRAW,    16'h0000, 6'd0,  30'd0,          1'b0, 30'd0},
		'{CMD_DUMP,    16'h0000, 6'd0,  30'd0,          1'b0, 30'd0}
	};

	subtractive_random_generator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// (a - b) mod 10^9, both below 10^9
	function automatic logic [WORD_W-1:0] mod_diff(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		int d;
		d = int'(a) - int'(b);
		if (d < 0) begin
			d += int'(MODULUS);
		end
		return d[WORD_W-1:0];
	endfunction

	// table positions run 1..55; anything else reads as zero and is never written
	function automatic logic [WORD_W-1:0] word_at(input int p);
		if (p >= 1 && p <= TABLE_LEN) begin
			return lag_words[p-1];
		end
		return '0;
	endfunction

	function automatic void put_word(input int p, input logic [WORD_W-1:0] v);
		if (p >= 1 && p <= TABLE_LEN) begin
			lag_words[p-1] = v;
		end
	endfunction

	function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] p);
		return (int'(p) >= TABLE_LEN) ? IDX_W'(1) : p + 1'b1;
	endfunction

	// seeding: seed word at 55, scattered fill at (21*i) mod 55, then the warm-up passes
	task automatic reseed(input logic [SEED_W-1:0] sd);
		int sv, mag, cur, prev, nxt;
		sv   = int'($signed(sd));
		mag  = (sv < 0) ? -sv : sv;
		cur  = (int'(SEED_BASE) - mag) % int'(MODULUS);
		put_word(TABLE_LEN, cur[WORD_W-1:0]);
		prev = 1;
		for (int i = 1; i <= FILL_COUNT; i++) begin
			put_word((SPREAD * i) % TABLE_LEN, prev[WORD_W-1:0]);
			nxt  = int'(mod_diff(cur[WORD_W-1:0], prev[WORD_W-1:0]));
			cur  = prev;
			prev = nxt;
		end
		for (int pass = 0; pass < WARM_PASSES; pass++) begin
			for (int i = 1; i <= TABLE_LEN; i++) begin
				put_word(i, mod_diff(word_at(i), word_at(1 + (i + LAG_OFFSET) % TABLE_LEN)));
			end
		end
		first_pos  = '0;
		second_pos = IDX_W'(SECOND_START);
	endtask

	// works out the result items of one accepted command and updates the state copy
	task automatic step_generator(input cmd_t c, input logic [SEED_W-1:0] sd,
			input logic [IDX_W-1:0] wi, input logic [WORD_W-1:0] wv);
		logic [WORD_W-1:0] v;
		step_out.delete();
		case (c)
			CMD_SEED: begin
				reseed(sd);
				step_out.push_back('{'0, 1'b1});
			end
			CMD_DRAW: begin
				first_pos  = advance(first_pos);
				second_pos = advance(second_pos);
				v = mod_diff(word_at(int'(first_pos)), word_at(int'(second_pos)));
				put_word(int'(first_pos), v);
				step_out.push_back('{v, 1'b1});
			end
			CMD_DUMP: begin
				for (int k = 0; k < TABLE_LEN; k++) begin
					step_out.push_back('{lag_words[k], 1'b0});
				end
				step_out.push_back('{WORD_W'(first_pos), 1'b0});
				step_out.push_back('{WORD_W'(second_pos), 1'b1});
			end
			default: begin
				if (int'(wi) < TABLE_LEN) begin
					lag_words[wi] = (wv > MAX_WORD) ? MAX_WORD : wv;
				end else if (wi == WIDX_FIRST) begin
					first_pos = (wv > TABLE_LEN) ? IDX_W'(TABLE_LEN) : wv[IDX_W-1:0];
				end else if (wi == WIDX_SECOND) begin
					second_pos = (wv > TABLE_LEN) ? IDX_W'(TABLE_LEN) : wv[IDX_W-1:0];
				end
				step_out.push_back('{'0, 1'b1});
			end
		endcase
	endtask

	// present one item, hold it until taken, then record what it should cause
	task automatic send_item(input cmd_t c, input logic [SEED_W-1:0] sd,
			input logic [IDX_W-1:0] wi, input logic [WORD_W-1:0] wv,
			input logic fixed, input logic [WORD_W-1:0] fixed_value);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {4'b0, wv, wi, sd};
		do @(posedge clk); while (!s_tready);
		step_generator(c, sd, wi, wv);
		if (fixed) begin
			due_outputs.push_back('{fixed_value, 1'b1});
		end else begin
			foreach (step_out[k]) due_outputs.push_back(step_out[k]);
		end
	endtask

	// sender holds off until every owed result has come out
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		while (due_outputs.size() != 0) @(posedge clk);
	endtask

	// mostly draws after seeds; restores hit table, status or unused word numbers, random content
	task automatic random_item();
		int                r, q;
		cmd_t              c;
		logic [SEED_W-1:0] sd;
		logic [IDX_W-1:0]  wi;
		logic [WORD_W-1:0] wv;
		r  = $urandom_range(0, 99);
		sd = SEED_W'($urandom);
		wi = IDX_W'($urandom);
		wv = WORD_W'($urandom);
		if (r < 8) begin
			c = CMD_SEED;
		end else if (r < 62) begin
			c = CMD_DRAW;
		end else if (r < 72) begin
			c = CMD_DUMP;
		end else begin
			c = CMD_RESTORE;
			q = $urandom_range(0, 9);
			if (q < 6) begin
				wi = IDX_W'($urandom_range(0, TABLE_LEN - 1));
				if ($urandom_range(0, 7) != 0) wv = WORD_W'($urandom_range(0, int'(MAX_WORD)));
			end else if (q < 9) begin
				wi = ($urandom_range(0, 1) == 0) ? WIDX_FIRST : WIDX_SECOND;
				if ($urandom_range(0, 3) != 0) wv = WORD_W'($urandom_range(0, TABLE_LEN));
			end else begin
				wi = IDX_W'($urandom_range(int'(WIDX_SECOND) + 1, 63));
			end
		end
		send_item(c, sd, wi, wv, 1'b0, '0);
	endtask

	// compare one taken result item against the oldest owed one
	task automatic check_output(input logic [WORD_W-1:0] got_value, input logic got_last);
		gen_out_t want;
		if (due_outputs.size() == 0) begin
			if (mismatches < 10) begin
				$display("unexpected result item: value %0d last %0b", got_value, got_last);
			end
			mismatches++;
		end else begin
			want = due_outputs.pop_front();
			if (got_value !== want.value || got_last !== want.last) begin
				if (mismatches < 10) begin
					$display("result item mismatch: value exp %0d got %0d, last exp %0b got %0b",
						want.value, got_value, want.last, got_last);
				end
				mismatches++;
			end
		end
	endtask

	// receiver: check on handshake, stall in random bursts while idling is allowed
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			check_output(m_tdata[WORD_W-1:0], m_tlast);
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (arst_n && idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 11) - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// state copy starts as after reset
	initial begin
		foreach (lag_words[k]) lag_words[k] = '0;
		first_pos  = '0;
		second_pos = '0;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			send_item(directed_rows[n].cmd, directed_rows[n].seed, directed_rows[n].word_index,
				directed_rows[n].word_value, directed_rows[n].fixed, directed_rows[n].fixed_value);
		end
		drain_outputs();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == DRAIN_AT) drain_outputs();
			if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
			random_item();
		end
		drain_outputs();
		// every item yields a result, so only a short tail for stray items
		repeat (20) @(posedge clk);

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// ends the run with a mismatch report if the test has not finished in time
	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
